>>> rtl/adts_pkg.sv
package adts_pkg;

   localparam int ADTS_FIFO_DEPTH = 4;
   localparam int ADTS_PTR_W      = $clog2(ADTS_FIFO_DEPTH);
   localparam int ADTS_CNT_W      = $clog2(ADTS_FIFO_DEPTH + 1);

   localparam logic [7:0]  SYNC_BYTE0    = 8'hFF;
   localparam logic [7:0]  SYNC_B1_MASK  = 8'hF6;
   localparam logic [7:0]  SYNC_B1_VALUE = 8'hF0;
   localparam logic [12:0] MIN_FRAME_LEN = 13'd7;
   localparam logic [12:0] BODY_START    = 13'd6;
   localparam logic [12:0] LAST_HDR_IDX  = 13'd5;

   typedef enum logic {
      KIND_FRAME   = 1'b0,
      KIND_SUMMARY = 1'b1
   } adts_kind_type;

   typedef enum logic [1:0] {
      CAUSE_CLEAN     = 2'd0,
      CAUSE_BAD_SYNC  = 2'd1,
      CAUSE_TRUNCATED = 2'd2,
      CAUSE_SHORT     = 2'd3
   } adts_cause_type;

   typedef struct packed {
      adts_kind_type  record_kind;
      logic [31:0]    frame_offset;
      logic [12:0]    frame_size;
      logic [23:0]    frame_count;
      logic [31:0]    total_bytes;
      logic [16:0]    sample_rate_hz;
      adts_cause_type stop_cause;
      logic           last_of_run;
   } adts_result_type;

   typedef struct packed {
      logic frame_valid;
      logic summary_valid;
   } adts_push_type;

   // map the ADTS sampling frequency index to Hz; reserved indices give 0
   function automatic logic [16:0] adts_rate_hz(input logic [3:0] code);
      logic [16:0] hz;
      case (code)
         4'd0:    hz = 17'd96000;
         4'd1:    hz = 17'd88200;
         4'd2:    hz = 17'd64000;
         4'd3:    hz = 17'd48000;
         4'd4:    hz = 17'd44100;
         4'd5:    hz = 17'd32000;
         4'd6:    hz = 17'd24000;
         4'd7:    hz = 17'd22050;
         4'd8:    hz = 17'd16000;
         4'd9:    hz = 17'd12000;
         4'd10:   hz = 17'd11025;
         4'd11:   hz = 17'd8000;
         default: hz = 17'd0;
      endcase
      return hz;
   endfunction

endpackage

>>> rtl/adts_req_if.sv
interface adts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

>>> rtl/adts_rsp_if.sv
interface adts_rsp_if;
   logic        valid;
   logic        ready;
   logic        record_kind;
   logic [31:0] frame_offset;
   logic [12:0] frame_size;
   logic [23:0] frame_count;
   logic [31:0] total_bytes;
   logic [16:0] sample_rate_hz;
   logic [1:0]  stop_cause;
   logic        last_of_run;

   modport source (
      output valid, output record_kind, output frame_offset, output frame_size,
      output frame_count, output total_bytes, output sample_rate_hz,
      output stop_cause, output last_of_run, input ready
   );
   modport sink (
      input valid, input record_kind, input frame_offset, input frame_size,
      input frame_count, input total_bytes, input sample_rate_hz,
      input stop_cause, input last_of_run, output ready
   );
endinterface

>>> rtl/adts_rsp_fifo.sv
module adts_rsp_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  adts_pkg::adts_push_type  push,
   input  adts_pkg::adts_result_type frame_item,
   input  adts_pkg::adts_result_type summary_item,
   output logic                     has_room,
   adts_rsp_if.source               rsp_chan
);
   import adts_pkg::*;

   adts_result_type         mem [ADTS_FIFO_DEPTH];
   logic [ADTS_PTR_W-1:0]   wr_ptr_ff;
   logic [ADTS_PTR_W-1:0]   rd_ptr_ff;
   logic [ADTS_CNT_W-1:0]   count_ff;
   logic [ADTS_CNT_W-1:0]   n_push;
   logic [ADTS_PTR_W-1:0]   summary_addr;
   logic                    pop;
   adts_result_type         head;

   assign n_push = ADTS_CNT_W'(push.frame_valid) + ADTS_CNT_W'(push.summary_valid);
   assign summary_addr = wr_ptr_ff + ADTS_PTR_W'(push.frame_valid);
   assign pop = rsp_chan.valid & rsp_chan.ready;
   // room for the worst case of two results from one byte
   assign has_room = count_ff <= ADTS_CNT_W'(ADTS_FIFO_DEPTH - 2);

   always_ff @(posedge clock) begin
      if (push.frame_valid) begin
         mem[wr_ptr_ff] <= frame_item;
      end
      if (push.summary_valid) begin
         mem[summary_addr] <= summary_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + ADTS_PTR_W'(n_push);
         rd_ptr_ff <= rd_ptr_ff + ADTS_PTR_W'(pop);
         count_ff  <= count_ff + n_push - ADTS_CNT_W'(pop);
      end
   end

   assign head                    = mem[rd_ptr_ff];
   assign rsp_chan.valid          = count_ff != '0;
   assign rsp_chan.record_kind    = head.record_kind;
   assign rsp_chan.frame_offset   = head.frame_offset;
   assign rsp_chan.frame_size     = head.frame_size;
   assign rsp_chan.frame_count    = head.frame_count;
   assign rsp_chan.total_bytes    = head.total_bytes;
   assign rsp_chan.sample_rate_hz = head.sample_rate_hz;
   assign rsp_chan.stop_cause     = head.stop_cause;
   assign rsp_chan.last_of_run    = head.last_of_run;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push.frame_valid || push.summary_valid) |-> has_room)
      else $error("result queue pushed without room");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ADTS_CNT_W'(ADTS_FIFO_DEPTH))
      else $error("result queue count out of range");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (!pop && push.frame_valid && push.summary_valid) |=> count_ff == $past(count_ff) + 2)
      else $error("result queue count lost a double push");

endmodule

>>> rtl/adts_frame_scanner.sv
// A byte accepted at a clock edge writes its results into the result queue at
// that edge; with the queue empty they are at its head in the next cycle.
// Throughput: one byte per clock; ready drops only while fewer than two queue
// slots are free, set by the four-entry result queue.
// Reset (synchronous, active high) clears all scan state and empties the queue.
module adts_frame_scanner (
   input  logic      clock,
   input  logic      reset,
   adts_req_if.sink   req_chan,
   adts_rsp_if.source rsp_chan
);
   import adts_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_BODY   = 2'd1,
      PH_STOP   = 2'd2
   } phase_type;

   // scan state
   phase_type      phase_ff,  phase_in;
   logic [12:0]    bif_ff,    bif_in;      // byte index within current frame
   logic [39:0]    hdr_ff,    hdr_in;      // first five header bytes
   logic [31:0]    pos_ff,    pos_in;      // stream position
   logic [31:0]    start_ff,  start_in;    // offset of current frame start
   logic [12:0]    len_ff,    len_in;      // current frame length
   logic [23:0]    frames_ff, frames_in;
   logic [31:0]    total_ff,  total_in;
   logic [3:0]     rate_ff,   rate_in;
   logic           first_ff,  first_in;
   adts_cause_type stop_ff,   stop_in;

   logic            accept;
   logic            has_room;
   logic            sync_ok;
   logic [12:0]     hdr_len;
   logic [32:0]     total_sum;
   logic            frame_push;
   adts_cause_type  end_cause;
   adts_push_type   push;
   adts_result_type frame_item;
   adts_result_type summary_item;

   assign accept = req_chan.valid & req_chan.ready;
   assign req_chan.ready = has_room;

   // header fields, valid while the sixth header byte is on the input
   assign sync_ok = (hdr_ff[7:0] == SYNC_BYTE0) &&
                    ((hdr_ff[15:8] & SYNC_B1_MASK) == SYNC_B1_VALUE);
   assign hdr_len   = {hdr_ff[25:24], hdr_ff[39:32], req_chan.data_byte[7:5]};
   assign total_sum = {1'b0, total_ff} + 33'(hdr_len);

   always_comb begin
      phase_in   = phase_ff;
      bif_in     = bif_ff;
      hdr_in     = hdr_ff;
      pos_in     = pos_ff + 32'd1;
      start_in   = start_ff;
      len_in     = len_ff;
      frames_in  = frames_ff;
      total_in   = total_ff;
      rate_in    = rate_ff;
      first_in   = first_ff;
      stop_in    = stop_ff;
      frame_push = 1'b0;
      end_cause  = CAUSE_CLEAN;

      case (phase_ff)
         PH_HEADER: begin
            if (bif_ff == '0) begin
               start_in = pos_ff;
            end
            if (bif_ff < LAST_HDR_IDX) begin
               // gather header byte into its lane
               hdr_in[{bif_ff[2:0], 3'b000} +: 8] = req_chan.data_byte;
               bif_in = bif_ff + 13'd1;
            end else begin
               hdr_in = '0;
               if (sync_ok) begin
                  len_in     = hdr_len;
                  frame_push = 1'b1;
                  if (!first_ff) begin
                     rate_in  = hdr_ff[21:18];
                     first_in = 1'b1;
                  end
                  // saturate the length total
                  total_in = total_sum[32] ? '1 : total_sum[31:0];
                  if (hdr_len < MIN_FRAME_LEN) begin
                     stop_in  = CAUSE_SHORT;
                     phase_in = PH_STOP;
                  end else begin
                     phase_in = PH_BODY;
                     bif_in   = BODY_START;
                  end
               end else begin
                  stop_in  = CAUSE_BAD_SYNC;
                  phase_in = PH_STOP;
               end
            end
         end
         PH_BODY: begin
            // skip frame payload; count the frame on its last byte
            if ({1'b0, bif_ff} + 14'd1 >= {1'b0, len_ff}) begin
               if (frames_ff != '1) begin
                  frames_in = frames_ff + 24'd1;
               end
               phase_in = PH_HEADER;
               bif_in   = '0;
            end else begin
               bif_in = bif_ff + 13'd1;
            end
         end
         default: begin
            // stopped: drop bytes until the final one
         end
      endcase

      // stop cause as seen after this byte
      case (phase_in)
         PH_HEADER: end_cause = CAUSE_CLEAN;
         PH_BODY:   end_cause = CAUSE_TRUNCATED;
         default:   end_cause = stop_in;
      endcase

      // summary item, built from the state after this byte
      summary_item.record_kind    = KIND_SUMMARY;
      summary_item.frame_offset   = '0;
      summary_item.frame_size     = '0;
      summary_item.frame_count    = frames_in;
      summary_item.total_bytes    = total_in;
      summary_item.sample_rate_hz = first_in ? adts_rate_hz(rate_in) : 17'd0;
      summary_item.stop_cause     = end_cause;
      summary_item.last_of_run    = 1'b1;

      frame_item.record_kind    = KIND_FRAME;
      frame_item.frame_offset   = start_ff;
      frame_item.frame_size     = hdr_len;
      frame_item.frame_count    = '0;
      frame_item.total_bytes    = '0;
      frame_item.sample_rate_hz = '0;
      frame_item.stop_cause     = CAUSE_CLEAN;
      frame_item.last_of_run    = !req_chan.final_byte;

      // end of stream: start over for the next stream
      if (req_chan.final_byte) begin
         phase_in  = PH_HEADER;
         bif_in    = '0;
         hdr_in    = '0;
         pos_in    = '0;
         start_in  = '0;
         len_in    = '0;
         frames_in = '0;
         total_in  = '0;
         rate_in   = '0;
         first_in  = 1'b0;
         stop_in   = CAUSE_CLEAN;
      end
   end

   assign push.frame_valid   = accept & frame_push;
   assign push.summary_valid = accept & req_chan.final_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         bif_ff    <= '0;
         hdr_ff    <= '0;
         pos_ff    <= '0;
         start_ff  <= '0;
         len_ff    <= '0;
         frames_ff <= '0;
         total_ff  <= '0;
         rate_ff   <= '0;
         first_ff  <= 1'b0;
         stop_ff   <= CAUSE_CLEAN;
      end else if (accept) begin
         phase_ff  <= phase_in;
         bif_ff    <= bif_in;
         hdr_ff    <= hdr_in;
         pos_ff    <= pos_in;
         start_ff  <= start_in;
         len_ff    <= len_in;
         frames_ff <= frames_in;
         total_ff  <= total_in;
         rate_ff   <= rate_in;
         first_ff  <= first_in;
         stop_ff   <= stop_in;
      end
   end

   // result queue: holds items while the sink stalls
   adts_rsp_fifo u_rsp_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .frame_item   (frame_item),
      .summary_item (summary_item),
      .has_room     (has_room),
      .rsp_chan     (rsp_chan)
   );

   a_final_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.final_byte) |=>
         (phase_ff == PH_HEADER && pos_ff == '0 && frames_ff == '0 && !first_ff))
      else $error("scan state not restarted after final byte");

   a_body_index: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (bif_ff >= BODY_START && bif_ff < len_ff))
      else $error("body byte index outside frame");

   a_header_index: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HEADER) |-> (bif_ff <= LAST_HDR_IDX))
      else $error("header byte index past sixth byte");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_chan.final_byte) |=> (frames_ff >= $past(frames_ff)))
      else $error("frame count went backward within a stream");

endmodule

>>> dv/adts_frame_scanner_tb.sv
module adts_frame_scanner_tb;
   import adts_pkg::*;

   // quiet cycles (no item moving on either side) before the run is called hung
   localparam int QUIET_LIMIT   = 1000;
   // mismatch reports beyond this are counted but not printed
   localparam int REPORT_LIMIT  = 30;
   // settle time after the last expected record has arrived
   localparam int TAIL_CYCLES   = 8;
   localparam int RANDOM_ITEMS  = 340;

   typedef enum logic [1:0] {
      SCAN_HEADER = 2'd0,
      SCAN_BODY   = 2'd1,
      SCAN_HALTED = 2'd2
   } scan_state_type;

   logic clock = 1'b0;
   logic reset;

   adts_req_if req_chan ();
   adts_rsp_if rsp_chan ();

   adts_frame_scanner uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Scan predictor: a private copy of the scanner state, advanced once per
   // accepted item. Records it produces wait in records_due until the block
   // delivers them.
   // ---------------------------------------------------------------------
   scan_state_type  scan_state;
   logic [12:0]     byte_idx;
   logic [12:0]     frame_len;
   logic [39:0]     hdr_buf;
   logic [31:0]     stream_pos;
   logic [31:0]     frame_start;
   logic [31:0]     bytes_claimed;
   logic [23:0]     frames_done;
   logic [3:0]      rate_idx;
   logic            rate_locked;
   adts_cause_type  halt_cause;

   int unsigned rate_hz_table [12] = '{
      96000, 88200, 64000, 48000, 44100, 32000,
      24000, 22050, 16000, 12000, 11025, 8000
   };

   adts_result_type records_due [$];

   // run statistics
   int bytes_sent       = 0;
   int frames_predicted = 0;
   int records_checked  = 0;
   int cause_seen [4]   = '{0, 0, 0, 0};
   int mismatches       = 0;

   // traffic shaping
   bit calm = 1'b0;
   int cycle_count = 0;
   int stall_left = 0;
   int quiet_cycles = 0;

   adts_result_type due;

   // return the scanner copy to its post-reset state; also runs after every
   // final byte, since each stream starts from scratch
   task automatic clear_scan_model();
      scan_state    = SCAN_HEADER;
      byte_idx      = '0;
      frame_len     = '0;
      hdr_buf       = '0;
      stream_pos    = '0;
      frame_start   = '0;
      bytes_claimed = '0;
      frames_done   = '0;
      rate_idx      = '0;
      rate_locked   = 1'b0;
      halt_cause    = CAUSE_CLEAN;
   endtask

   // advance the scanner copy by one byte and queue the records it causes
   task automatic predict_records(input logic [7:0] data, input logic fin);
      adts_result_type rec;
      logic [31:0]     here;
      logic [7:0]      h0, h1, h2, h3, h4;
      logic [12:0]     len;
      logic [32:0]     sum;
      adts_cause_type  cause;
      here = stream_pos;
      stream_pos = stream_pos + 32'd1;
      case (scan_state)
         SCAN_HEADER: begin
            if (byte_idx == 13'd0)
               frame_start = here;
            if (byte_idx < LAST_HDR_IDX) begin
               hdr_buf[byte_idx * 8 +: 8] = data;
               byte_idx = byte_idx + 13'd1;
            end else begin
               // sixth header byte: decide on the five held bytes plus this one
               {h4, h3, h2, h1, h0} = hdr_buf;
               hdr_buf = '0;
               if (h0 != SYNC_BYTE0 || (h1 & SYNC_B1_MASK) != SYNC_B1_VALUE) begin
                  halt_cause = CAUSE_BAD_SYNC;
                  scan_state = SCAN_HALTED;
               end else begin
                  len = {h3[1:0], h4, data[7:5]};
                  frame_len = len;
                  // only the first good header of a stream sets the rate
                  if (!rate_locked) begin
                     rate_idx    = h2[5:2];
                     rate_locked = 1'b1;
                  end
                  rec = '0;
                  rec.record_kind  = KIND_FRAME;
                  rec.frame_offset = frame_start;
                  rec.frame_size   = len;
                  rec.last_of_run  = !fin;
                  records_due.push_back(rec);
                  frames_predicted++;
                  // the length is claimed even if the frame never completes
                  sum = {1'b0, bytes_claimed} + {20'd0, len};
                  bytes_claimed = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                  if (len < MIN_FRAME_LEN) begin
                     halt_cause = CAUSE_SHORT;
                     scan_state = SCAN_HALTED;
                  end else begin
                     scan_state = SCAN_BODY;
                     byte_idx   = BODY_START;
                  end
               end
            end
         end
         SCAN_BODY: begin
            // widen by one bit so the index of the longest frame cannot wrap
            if ({1'b0, byte_idx} + 14'd1 >= {1'b0, frame_len}) begin
               if (frames_done != '1)
                  frames_done = frames_done + 24'd1;
               scan_state = SCAN_HEADER;
               byte_idx   = '0;
            end else begin
               byte_idx = byte_idx + 13'd1;
            end
         end
         default: ;  // halted: drop the byte
      endcase

      if (fin) begin
         case (scan_state)
            SCAN_HEADER: cause = CAUSE_CLEAN;
            SCAN_BODY:   cause = CAUSE_TRUNCATED;
            default:     cause = halt_cause;
         endcase
         rec = '0;
         rec.record_kind = KIND_SUMMARY;
         rec.frame_count = frames_done;
         rec.total_bytes = bytes_claimed;
         if (rate_locked && rate_idx < 4'd12)
            rec.sample_rate_hz = 17'(rate_hz_table[rate_idx]);
         rec.stop_cause  = cause;
         rec.last_of_run = 1'b1;
         records_due.push_back(rec);
         cause_seen[cause]++;
         clear_scan_model();
      end
   endtask

   // ---------------------------------------------------------------------
   // Traffic shaping shared by both sides: mostly short gaps, a few long
   // ones, and stretches of full rate while calm is set.
   // ---------------------------------------------------------------------
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 60);
   endfunction

   // at each wrap of cycle_count's low byte, pick a calm or a noisy stretch
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count[7:0] == 8'd0)
         calm <= ($urandom_range(0, 3) == 0);
   end

   // result side: stall at random; no new stall starts while calm
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 99) < 30) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= gap_length() - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Checking: every delivered record against the oldest one due.
   // ---------------------------------------------------------------------
   function automatic void check_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (records_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $error("record delivered with none due: kind %0d offset %0d",
                      rsp_chan.record_kind, rsp_chan.frame_offset);
         end else begin
            due = records_due.pop_front();
            records_checked++;
            check_field("record_kind", due.record_kind, rsp_chan.record_kind);
            check_field("frame_offset", due.frame_offset, rsp_chan.frame_offset);
            check_field("frame_size", due.frame_size, rsp_chan.frame_size);
            check_field("frame_count", due.frame_count, rsp_chan.frame_count);
            check_field("total_bytes", due.total_bytes, rsp_chan.total_bytes);
            check_field("sample_rate_hz", due.sample_rate_hz, rsp_chan.sample_rate_hz);
            check_field("stop_cause", due.stop_cause, rsp_chan.stop_cause);
            check_field("last_of_run", due.last_of_run, rsp_chan.last_of_run);
         end
      end
   end

   // watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles, %0d records still due",
                  QUIET_LIMIT, records_due.size());
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   // Send one byte. Valid stays high after acceptance so back-to-back items
   // need only one assignment per falling edge; the next send, when it has a gap,
   // or drain_records, takes it down at the following falling edge.
   task automatic send_byte(input logic [7:0] data, input logic fin);
      int gap;
      gap = (calm || $urandom_range(0, 99) >= 35) ? 0 : gap_length();
      @(negedge clock);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.data_byte  <= data;
      req_chan.final_byte <= fin;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      predict_records(data, fin);
      bytes_sent++;
   endtask

   // send n random bytes, the last one closing the stream
   task automatic send_tail(input int n);
      for (int i = 0; i < n; i++)
         send_byte(8'($urandom_range(0, 255)), i == n - 1);
   endtask

   // Send the first count bytes of one frame: a six-byte header carrying the
   // given sync bytes, length and rate index, then random body bytes. The
   // byte at index fin_at (if any) is marked final and ends the send.
   task automatic send_frame(input logic [12:0] len, input logic [3:0] rate_code,
                             input logic [7:0] sync0, input logic [7:0] sync1,
                             input int count, input int fin_at, output bit ended);
      logic [7:0]  hdr [0:5];
      logic [31:0] noise;
      logic [7:0]  octet;
      noise  = $urandom;
      hdr[0] = sync0;
      hdr[1] = sync1;
      hdr[2] = {noise[7:6], rate_code, noise[1:0]};
      hdr[3] = {noise[13:8], len[12:11]};
      hdr[4] = len[10:3];
      hdr[5] = {len[2:0], noise[20:16]};
      ended  = 1'b0;
      for (int i = 0; i < count && !ended; i++) begin
         octet = (i < 6) ? hdr[i] : 8'($urandom_range(0, 255));
         ended = (i == fin_at);
         send_byte(octet, ended);
      end
   endtask

   // drop valid and hold until the block has delivered every record due
   task automatic drain_records();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (records_due.size() != 0)
         @(posedge clock);
   endtask

   // one-byte stream and a minimal frame that ends exactly on its last byte
   task automatic test_clean_ends();
      bit done;
      send_byte(SYNC_BYTE0, 1'b1);
      send_frame(13'd7, 4'd0, SYNC_BYTE0, 8'hF1, 7, 6, done);
   endtask

   // every way a scan can stop early, all with the final byte on the
   // sixth header byte; includes the zero and the all-ones frame length
   task automatic test_stop_causes();
      bit done;
      send_frame(13'd7, 4'd3, 8'hFE, SYNC_B1_VALUE, 6, 5, done);
      send_frame(13'd0, 4'd15, SYNC_BYTE0, 8'hF9, 6, 5, done);
      send_frame(13'h1FFF, 4'd11, SYNC_BYTE0, 8'hF9, 6, 5, done);
   endtask

   // Random streams: mostly chains of well-formed frames with random header
   // content, some broken sync, short lengths, truncation and plain noise.
   task automatic test_random_streams(input int budget);
      int          first;
      int          frames;
      int          pick;
      int          fin_at;
      bit          ended;
      bit          halted;
      logic [12:0] len;
      logic [7:0]  sync0;
      logic [7:0]  sync1;
      logic [7:0]  noise;
      first = bytes_sent;
      while (bytes_sent - first < budget) begin
         if ($urandom_range(0, 99) < 8) begin
            send_tail($urandom_range(1, 10));
         end else begin
            frames = $urandom_range(1, 4);
            ended  = 1'b0;
            for (int f = 0; f < frames && !ended; f++) begin
               pick  = $urandom_range(0, 99);
               noise = 8'($urandom_range(0, 255));
               sync0 = SYNC_BYTE0;
               // the bits outside the sync mask are free
               sync1 = SYNC_B1_VALUE | (noise & ~SYNC_B1_MASK);
               len   = (pick < 85) ? 13'($urandom_range(7, 24))
                                   : 13'($urandom_range(25, 90));
               halted = 1'b1;
               if (pick < 5) begin
                  sync0 = 8'($urandom_range(0, 254));
               end else if (pick < 9) begin
                  sync1 = 8'($urandom_range(0, 255));
                  if ((sync1 & SYNC_B1_MASK) == SYNC_B1_VALUE)
                     sync1 = sync1 ^ 8'h04;
               end else if (pick < 14) begin
                  len = 13'($urandom_range(0, 6));
               end else begin
                  halted = 1'b0;
               end

               // pick where the stream ends; a stopped scan ignores its body,
               // so send only the header of a frame that will stop it
               fin_at = -1;
               pick   = $urandom_range(0, 99);
               if (halted) begin
                  if (pick < 30)
                     fin_at = $urandom_range(0, 5);
               end else if (f == frames - 1) begin
                  if (pick < 55 || len == MIN_FRAME_LEN)
                     fin_at = int'(len) - 1;
                  else if (pick < 75)
                     fin_at = $urandom_range(6, int'(len) - 2);
                  else if (pick < 85)
                     fin_at = $urandom_range(0, 5);
               end
               send_frame(len, 4'($urandom_range(0, 15)), sync0, sync1,
                          halted ? 6 : int'(len), fin_at, ended);

               // close the stream: ignored bytes after a stop, or a partial
               // next header after a complete frame
               if (!ended && (halted || f == frames - 1)) begin
                  send_tail($urandom_range(1, 5));
                  ended = 1'b1;
               end
            end
         end
      end
   endtask

   // hold the sender in the middle of a frame body until the block is empty
   task automatic test_pause_mid_frame();
      bit done;
      send_frame(13'd20, 4'd4, SYNC_BYTE0, SYNC_B1_VALUE, 10, -1, done);
      drain_records();
      send_tail(10);
   endtask

   initial begin
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.data_byte  = '0;
      req_chan.final_byte = 1'b0;
      rsp_chan.ready      = 1'b0;
      clear_scan_model();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_clean_ends();
      test_stop_causes();
      test_random_streams(RANDOM_ITEMS);
      test_pause_mid_frame();
      test_random_streams(RANDOM_ITEMS);

      drain_records();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d bytes in %0d streams; %0d records checked, %0d of them frames",
               bytes_sent, cause_seen[0] + cause_seen[1] + cause_seen[2] + cause_seen[3],
               records_checked, frames_predicted);
      $display("stream endings: clean %0d, bad sync %0d, truncated %0d, short length %0d",
               cause_seen[CAUSE_CLEAN], cause_seen[CAUSE_BAD_SYNC],
               cause_seen[CAUSE_TRUNCATED], cause_seen[CAUSE_SHORT]);
      if (mismatches == 0 && records_due.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> adts_frame_scanner.f
rtl/adts_pkg.sv
rtl/adts_req_if.sv
rtl/adts_rsp_if.sv
rtl/adts_rsp_fifo.sv
rtl/adts_frame_scanner.sv
dv/adts_frame_scanner_tb.sv
